// ----- hdl/geodetic_to_cartesian_defines.svh -----
// Assertion macros shared by the geodetic to Cartesian checker.
`ifndef GEODETIC_TO_CARTESIAN_DEFINES_SVH
`define GEODETIC_TO_CARTESIAN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define G2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define G2C_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/g2c_pkg.sv -----
// Package with constants, types and the arctangent table of the converter.
`default_nettype none
package g2c_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MULT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 4'd1;

  localparam logic [31:0] SCALE_MULT_RST  = 32'd1;
  localparam logic [5:0]  SCALE_SHIFT_RST = 6'd0;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [32:0] QUARTER_TURN    = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN       = 33'sd2147483648;
  localparam logic signed [33:0] EQ_RADIUS_Q8    = 34'sd1632803840;
  localparam logic [22:0]        FLAT_RADIUS_Q8  = 23'd5474670;
  localparam logic [63:0]        HALF_Q30        = 64'd536870912;

  localparam logic [39:0] OUT_MAX_POS = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] OUT_MIN_NEG = 40'h80_0000_0000;
  localparam logic [42:0] OUT_LIM_NEG = 43'h080_0000_0000;

  // The unused code behaves as a given radius.
  typedef enum logic [1:0] {
    OP_SURFACE  = 2'd0,
    OP_DEPTH    = 2'd1,
    OP_RADIUS   = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef struct packed {
    logic               rneg;
    logic [31:0]        rmag;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } radius_t;

  function automatic logic [31:0] arctan(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/g2c_if.sv -----
// Channel interfaces of the converter: input points, results and configuration writes.
`default_nettype none
interface g2c_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [31:0] distance;
  modport source (output valid, operation, latitude, longitude, distance, input ready);
  modport sink (input valid, operation, latitude, longitude, distance, output ready);
endinterface

interface g2c_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] x_pos;
  logic signed [39:0] y_pos;
  logic signed [39:0] z_pos;
  modport source (output valid, x_pos, y_pos, z_pos, input ready);
  modport sink (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface g2c_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [g2c_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/g2c_cordic.sv -----
// Pipelined rotation-mode CORDIC giving Q2.30 cosine and sine of a half-turn angle.
`default_nettype none
module g2c_cordic #(
  parameter int STAGES = g2c_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] angle,
  output logic signed [31:0]      cos_q30,
  output logic signed [31:0]      sin_q30
);

  logic signed [33:0] x_r [0:STAGES];
  logic signed [33:0] y_r [0:STAGES];
  logic signed [32:0] z_r [0:STAGES];
  logic               flip_r [0:STAGES];
  logic signed [32:0] ang_ext;
  logic signed [32:0] z0_nxt;
  logic               flip_nxt;
  logic signed [31:0] cos_r, sin_r;

  always_comb begin
    ang_ext  = 33'(angle);
    z0_nxt   = ang_ext;
    flip_nxt = 1'b0;
    if (ang_ext > g2c_pkg::QUARTER_TURN) begin
      z0_nxt   = ang_ext - g2c_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end else if (ang_ext < -g2c_pkg::QUARTER_TURN) begin
      z0_nxt   = ang_ext + g2c_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= g2c_pkg::CORDIC_GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= z0_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [33:0] x_nxt, y_nxt;
    logic signed [32:0] z_nxt;
    logic signed [32:0] atan;

    always_comb begin
      atan = $signed({1'b0, g2c_pkg::arctan(i)});
      if (!z_r[i][32]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= flip_r[STAGES] ? 32'(-x_r[STAGES]) : 32'(x_r[STAGES]);
      sin_r <= flip_r[STAGES] ? 32'(-y_r[STAGES]) : 32'(y_r[STAGES]);
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule
`default_nettype wire

// ----- hdl/g2c_radius.sv -----
// Trig products, surface radius and radius selection in four pipeline stages.
`default_nettype none
module g2c_radius (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               valid_in,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] distance,
  input  wire logic signed [31:0] cl,
  input  wire logic signed [31:0] sl,
  input  wire logic signed [31:0] co,
  input  wire logic signed [31:0] so,
  output logic                    valid_out,
  output g2c_pkg::radius_t        res
);

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [63:0] ss_r, cc_r, cs_r;
  logic signed [31:0] sl1_r, sl2_r, sl3_r;
  logic [1:0]         op1_r, op2_r, op3_r;
  logic signed [31:0] dist1_r, dist2_r, dist3_r;
  logic [31:0]        s2_r;
  logic signed [31:0] fx2_r, fy2_r, fx3_r, fy3_r;
  logic [54:0]        flat_r;
  g2c_pkg::radius_t   res_r;

  logic signed [63:0] ss_sum, cc_sum, cs_sum;
  logic [55:0]        flat_sum;
  logic [25:0]        flat_q;
  logic signed [33:0] base, r;
  g2c_pkg::radius_t   res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    ss_sum = ss_r + $signed(g2c_pkg::HALF_Q30);
    cc_sum = cc_r + $signed(g2c_pkg::HALF_Q30);
    cs_sum = cs_r + $signed(g2c_pkg::HALF_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss_r    <= sl * sl;
      cc_r    <= cl * co;
      cs_r    <= cl * so;
      sl1_r   <= sl;
      op1_r   <= op;
      dist1_r <= distance;

      s2_r    <= ss_sum[61:30];
      fx2_r   <= cc_sum[61:30];
      fy2_r   <= cs_sum[61:30];
      sl2_r   <= sl1_r;
      op2_r   <= op1_r;
      dist2_r <= dist1_r;

      flat_r  <= g2c_pkg::FLAT_RADIUS_Q8 * s2_r;
      fx3_r   <= fx2_r;
      fy3_r   <= fy2_r;
      sl3_r   <= sl2_r;
      op3_r   <= op2_r;
      dist3_r <= dist2_r;

      res_r   <= res_nxt;
    end
  end

  always_comb begin
    flat_sum = {1'b0, flat_r} + g2c_pkg::HALF_Q30[55:0];
    flat_q   = flat_sum[55:30];
    base     = g2c_pkg::EQ_RADIUS_Q8 - $signed({8'd0, flat_q});
    case (g2c_pkg::op_t'(op3_r))
      g2c_pkg::OP_SURFACE: r = base;
      g2c_pkg::OP_DEPTH:   r = base - 34'(dist3_r);
      default:             r = 34'(dist3_r);
    endcase
    res_nxt.rneg = r[33];
    res_nxt.rmag = r[33] ? 32'(-r) : 32'(r);
    res_nxt.fx   = fx3_r;
    res_nxt.fy   = fy3_r;
    res_nxt.fz   = sl3_r;
  end

  assign valid_out = v4_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ----- hdl/g2c_scale.sv -----
// Radius scaling, per-axis products and saturation in four pipeline stages.
`default_nettype none
module g2c_scale (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             valid_in,
  input  wire g2c_pkg::radius_t rad,
  input  wire logic [31:0]      scale_mult,
  input  wire logic [5:0]       scale_shift,
  output logic                  valid_out,
  output logic signed [39:0]    x_pos,
  output logic signed [39:0]    y_pos,
  output logic signed [39:0]    z_pos
);

  logic               v5_r, v6_r, v7_r, v8_r;
  logic [63:0]        prod_r, m_r;
  logic [31:0]        tm5_r [3];
  logic [31:0]        tm6_r [3];
  logic               neg5_r [3];
  logic               neg6_r [3];
  logic               neg7_r [3];
  logic [63:0]        hi_r [3];
  logic [63:0]        lo_r [3];
  logic signed [39:0] out_r [3];

  logic signed [31:0] fac [3];
  logic signed [39:0] out_nxt [3];
  logic [42:0]        mag [3];
  logic               big [3];

  assign fac[0] = rad.fx;
  assign fac[1] = rad.fy;
  assign fac[2] = rad.fz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v5_r <= valid_in;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= rad.rmag * scale_mult;
      m_r    <= prod_r >> scale_shift;
      for (int k = 0; k < 3; k++) begin
        tm5_r[k]  <= fac[k][31] ? 32'(-fac[k]) : 32'(fac[k]);
        neg5_r[k] <= rad.rneg ^ fac[k][31];
        tm6_r[k]  <= tm5_r[k];
        neg6_r[k] <= neg5_r[k];
        hi_r[k]   <= m_r[63:32] * tm6_r[k];
        lo_r[k]   <= m_r[31:0] * tm6_r[k];
        neg7_r[k] <= neg6_r[k];
        out_r[k]  <= out_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      big[k] = |hi_r[k][63:40];
      mag[k] = {hi_r[k][40:0], 2'b00} + {9'd0, lo_r[k][63:30]};
      if (neg7_r[k]) begin
        if (big[k] || mag[k] > g2c_pkg::OUT_LIM_NEG) begin
          out_nxt[k] = g2c_pkg::OUT_MIN_NEG;
        end else begin
          out_nxt[k] = 40'(-mag[k]);
        end
      end else begin
        if (big[k] || mag[k] > {3'd0, g2c_pkg::OUT_MAX_POS}) begin
          out_nxt[k] = g2c_pkg::OUT_MAX_POS;
        end else begin
          out_nxt[k] = mag[k][39:0];
        end
      end
    end
  end

  assign valid_out = v8_r;
  assign x_pos     = out_r[0];
  assign y_pos     = out_r[1];
  assign z_pos     = out_r[2];

endmodule
`default_nettype wire

// ----- hdl/geodetic_to_cartesian.sv -----
// Top level of the geodetic to Cartesian converter.
// The converter takes one point per clock while the output is not stalled and
// returns one scaled Cartesian point for each. The path runs through one input
// register, the two parallel sine/cosine pipelines, the trig product and radius
// stages, and the scaling, axis product and saturation stages. The whole pipeline
// advances together and holds while a finished result waits at the output, so a
// stall loses no transaction. Configuration writes are always accepted and take
// effect on items that reach the scaling stages after the write.
`default_nettype none
module geodetic_to_cartesian #(
  parameter int CORDIC_STAGES = g2c_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  g2c_in_if.sink     in_ch,
  g2c_out_if.source  out_ch,
  g2c_cfg_if.sink    cfg_ch
);

  localparam int CORDIC_LAT = CORDIC_STAGES + 2;

  logic               en;
  logic               out_vld;
  logic [31:0]        scale_mult_r;
  logic [5:0]         scale_shift_r;
  logic               in_vld_r;
  logic [1:0]         op_in_r;
  logic signed [31:0] lat_in_r, lon_in_r, dist_in_r;
  logic               vld_d_r [CORDIC_LAT];
  logic [1:0]         op_d_r [CORDIC_LAT];
  logic signed [31:0] dist_d_r [CORDIC_LAT];
  logic signed [31:0] cl, sl, co, so;
  logic               rad_vld;
  g2c_pkg::radius_t   rad;

  assign en           = !out_vld || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mult_r  <= g2c_pkg::SCALE_MULT_RST;
      scale_shift_r <= g2c_pkg::SCALE_SHIFT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        g2c_pkg::CFG_SCALE_MULT:  scale_mult_r  <= cfg_ch.data;
        g2c_pkg::CFG_SCALE_SHIFT: scale_shift_r <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      for (int k = 0; k < CORDIC_LAT; k++) begin
        vld_d_r[k] <= 1'b0;
      end
    end else if (en) begin
      in_vld_r   <= in_ch.valid;
      vld_d_r[0] <= in_vld_r;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        vld_d_r[k] <= vld_d_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_in_r     <= in_ch.operation;
      lat_in_r    <= in_ch.latitude;
      lon_in_r    <= in_ch.longitude;
      dist_in_r   <= in_ch.distance;
      op_d_r[0]   <= op_in_r;
      dist_d_r[0] <= dist_in_r;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        op_d_r[k]   <= op_d_r[k-1];
        dist_d_r[k] <= dist_d_r[k-1];
      end
    end
  end

  g2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
    .clk     (clk),
    .en      (en),
    .angle   (lat_in_r),
    .cos_q30 (cl),
    .sin_q30 (sl)
  );

  g2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
    .clk     (clk),
    .en      (en),
    .angle   (lon_in_r),
    .cos_q30 (co),
    .sin_q30 (so)
  );

  g2c_radius u_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (vld_d_r[CORDIC_LAT-1]),
    .op        (op_d_r[CORDIC_LAT-1]),
    .distance  (dist_d_r[CORDIC_LAT-1]),
    .cl        (cl),
    .sl        (sl),
    .co        (co),
    .so        (so),
    .valid_out (rad_vld),
    .res       (rad)
  );

  g2c_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .valid_in    (rad_vld),
    .rad         (rad),
    .scale_mult  (scale_mult_r),
    .scale_shift (scale_shift_r),
    .valid_out   (out_vld),
    .x_pos       (out_ch.x_pos),
    .y_pos       (out_ch.y_pos),
    .z_pos       (out_ch.z_pos)
  );

  assign out_ch.valid = out_vld;

endmodule
`default_nettype wire

// ----- hdl/g2c_checker.sv -----
// Port-level assertion checker of the converter and its bind to the top level.
`default_nettype none
`include "geodetic_to_cartesian_defines.svh"
module g2c_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               cfg_ready,
  input wire logic signed [39:0] x_pos,
  input wire logic signed [39:0] y_pos,
  input wire logic signed [39:0] z_pos
);

  `G2C_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(x_pos) && $stable(y_pos) && $stable(z_pos),
    "Stalled result transaction changed or vanished.")

  `G2C_ASSERT_IMP(a_in_ready, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready),
    "Input ready does not follow the output stall.")

  `G2C_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready,
    "Configuration port refused a transaction.")

endmodule

bind geodetic_to_cartesian g2c_checker u_g2c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready),
  .x_pos     (out_ch.x_pos),
  .y_pos     (out_ch.y_pos),
  .z_pos     (out_ch.z_pos)
);
`default_nettype wire
